>>> design/aev_pkg.sv
// ----------------------------------------------------------------------------
// aev_pkg: shared types and constants for the ADSR envelope VCA
// Register indexes, phase and command codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aev_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DIV_W      = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLKLEN  = 3'd5;

    // configuration reset values
    localparam logic [14:0] RST_ATTACK  = 15'd100;
    localparam logic [14:0] RST_DECAY   = 15'd250;
    localparam logic [14:0] RST_SUSTAIN = 15'd16000;
    localparam logic [14:0] RST_RELEASE = 15'd50;
    localparam logic [15:0] RST_GAIN    = 16'd4096;
    localparam logic [8:0]  RST_BLKLEN  = 9'd64;

    // trigger command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [31:0] LEVEL_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    // controller to datapath strobes
    typedef struct packed {
        logic load_in;
        logic apply_cmd;
        logic rise_start;
        logic rise_mul;
        logic step;
        logic env1;
        logic env2;
        logic slope_start;
        logic slope_fix;
        logic interp;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_valid;
        logic block_start;
        logic rise_div;
        logic div_done;
        logic silent;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> design/aev_ifs.sv
// ----------------------------------------------------------------------------
// aev_ifs: request channels of the ADSR envelope VCA
// Input sample channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aev_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [14:0] velocity;
    logic        block_start;
    logic signed [15:0] audio_in;

    modport source (output valid, output cmd, output velocity, output block_start,
                    output audio_in, input ready);
    modport sink   (input valid, input cmd, input velocity, input block_start,
                    input audio_in, output ready);
endinterface

interface aev_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] audio_out;
    logic signed [15:0] env_out;

    modport source (output valid, output audio_out, output env_out, input ready);
    modport sink   (input valid, input audio_out, input env_out, output ready);
endinterface

interface aev_cfg_if;
    import aev_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/aev_div.sv
// ----------------------------------------------------------------------------
// aev_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aev_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [aev_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [aev_pkg::DIV_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [aev_pkg::DIV_W-1:0]      o_quotient
);
    import aev_pkg::*;

    localparam int unsigned CW = $clog2(DIV_W);

    logic [DIV_W-1:0] r_rem, r_quo, r_div;
    logic [DIV_W-1:0] n_rem, n_quo;
    logic [DIV_W:0]   rem_sh, diff;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic             bitq;

    // one restoring step
    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        bitq   = ~diff[DIV_W];
        n_rem  = bitq ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        n_quo  = {r_quo[DIV_W-2:0], bitq};
    end

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without a run");
`endif

endmodule

`default_nettype wire

>>> design/aev_ctrl.sv
// ----------------------------------------------------------------------------
// aev_ctrl: sequencer of the ADSR envelope VCA
// Walks each request through the block step (block start only), interpolation and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aev_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire aev_pkg::t_dp_sts i_sts,
    output aev_pkg::t_dp_cmd      o_cmd,
    output logic                  o_in_ready
);
    import aev_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CMD, S_RISE, S_RDIV, S_RMUL, S_STEP, S_ENV1, S_ENV2,
        S_SSTART, S_SDIV, S_SFIX, S_INTERP, S_OUT
    } t_state;

    t_state r_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_sts.in_valid)
                              r_state <= i_sts.block_start ? S_CMD : S_INTERP;
                S_CMD:    r_state <= S_RISE;
                S_RISE:   r_state <= i_sts.rise_div ? S_RDIV : S_STEP;
                S_RDIV:   if (i_sts.div_done) r_state <= S_RMUL;
                S_RMUL:   r_state <= S_STEP;
                S_STEP:   r_state <= S_ENV1;
                S_ENV1:   r_state <= S_ENV2;
                S_ENV2:   r_state <= i_sts.silent ? S_INTERP : S_SSTART;
                S_SSTART: r_state <= S_SDIV;
                S_SDIV:   if (i_sts.div_done) r_state <= S_SFIX;
                S_SFIX:   r_state <= S_INTERP;
                S_INTERP: r_state <= S_OUT;
                S_OUT:    if (i_sts.out_free) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // decode strobes
    always_comb begin
        o_cmd             = '0;
        o_cmd.load_in     = (r_state == S_IDLE) && i_sts.in_valid;
        o_cmd.apply_cmd   = (r_state == S_CMD);
        o_cmd.rise_start  = (r_state == S_RISE);
        o_cmd.rise_mul    = (r_state == S_RMUL);
        o_cmd.step        = (r_state == S_STEP);
        o_cmd.env1        = (r_state == S_ENV1);
        o_cmd.env2        = (r_state == S_ENV2);
        o_cmd.slope_start = (r_state == S_SSTART);
        o_cmd.slope_fix   = (r_state == S_SFIX);
        o_cmd.interp      = (r_state == S_INTERP);
        o_cmd.out_load    = (r_state == S_OUT) && i_sts.out_free;
        o_in_ready        = (r_state == S_IDLE);
    end

`ifndef SYNTHESIS
    a_bs_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in && i_sts.block_start |=> r_state == S_CMD)
        else $error("block start request skipped the step");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_state == S_IDLE) else $error("result not closed");
`endif

endmodule

`default_nettype wire

>>> design/aev_dp.sv
// ----------------------------------------------------------------------------
// aev_dp: datapath of the ADSR envelope VCA
// Configuration, envelope state, rise increments, slope and sample shaping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aev_dp #(
    parameter int unsigned MAX_BLOCK   = 256,
    parameter int unsigned SAMPLE_RATE = 48000
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire aev_pkg::t_dp_cmd i_cmd,
    output aev_pkg::t_dp_sts      o_sts,
    aev_cfg_if.sink               i_cfg,
    aev_in_if.sink                i_in,
    aev_out_if.source             o_out
);
    import aev_pkg::*;

    localparam int unsigned IW     = $clog2(MAX_BLOCK + 1);
    localparam int unsigned PER_MS = (SAMPLE_RATE / 1000 == 0) ? 1 : SAMPLE_RATE / 1000;
    localparam int unsigned PW     = IW + 19;

    // configuration
    logic [14:0]        r_attack, r_decay, r_sustain, r_release;
    logic signed [15:0] r_gain;
    logic [8:0]         r_blklen;

    // envelope state
    t_phase             r_phase, n_phase;
    logic [31:0]        r_level, n_level;
    logic [14:0]        r_hvel;
    logic [31:0]        r_rsl;
    logic signed [15:0] r_prev, r_cur;
    logic signed [31:0] r_slope;
    logic [IW-1:0]      r_idx;
    logic               r_out_valid;

    // request payload and intermediates
    logic [1:0]         r_cmdc;
    logic [14:0]        r_vel;
    logic               r_bs;
    logic signed [15:0] r_x;
    logic [31:0]        r_inc;
    logic [14:0]        r_e1;
    logic               r_neg;
    logic signed [PW-1:0] r_inter;
    logic signed [15:0] r_y, r_env_o;

    // combinational helpers
    logic [31:0]        blk32, len32, sus, range_sel;
    logic [IW-1:0]      len;
    logic [14:0]        ms_sel;
    logic               ph_rise;
    logic [32+IW-1:0]   rise_p;
    logic [31:0]        t_add, t_sub;
    logic               t_ovf;
    logic [29:0]        e1_p;
    logic signed [31:0] e2_p;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic               div_start, div_done;
    logic [31:0]        div_a, div_b, div_q;
    logic signed [32+IW:0] sl_p;
    logic signed [PW-1:0]  inter_n;
    logic signed [PW+15:0] y_p;
    logic signed [PW+3:0]  y_sh;
    logic signed [15:0]    y_sat;

    // effective block length, clamped to 1..MAX_BLOCK
    always_comb begin
        blk32 = {23'd0, r_blklen};
        if (blk32 == 32'd0)
            len32 = 32'd1;
        else if (blk32 > 32'(MAX_BLOCK))
            len32 = 32'(MAX_BLOCK);
        else
            len32 = blk32;
        len = len32[IW-1:0];
        sus = {r_sustain, 17'd0};
    end

    // pick time and range of the running phase
    always_comb begin
        unique case (r_phase)
            PH_ATTACK:  begin ms_sel = r_attack;  range_sel = LEVEL_MAX;       end
            PH_DECAY:   begin ms_sel = r_decay;   range_sel = LEVEL_MAX - sus; end
            PH_RELEASE: begin ms_sel = r_release; range_sel = r_rsl;           end
            default:    begin ms_sel = r_attack;  range_sel = LEVEL_MAX;       end
        endcase
        ph_rise = (r_phase == PH_ATTACK) || (r_phase == PH_DECAY) ||
                  (r_phase == PH_RELEASE);
        rise_p  = div_q * {{(32 - IW){1'b0}}, len};
    end

    // phase step on the level
    always_comb begin
        n_phase = r_phase;
        n_level = r_level;
        {t_ovf, t_add} = {1'b0, r_level} + {1'b0, r_inc};
        t_sub = (r_inc > r_level) ? 32'd0 : r_level - r_inc;
        unique case (r_phase)
            PH_ATTACK: begin
                if (t_ovf) begin
                    n_level = LEVEL_MAX;
                    n_phase = PH_DECAY;
                end else begin
                    n_level = t_add;
                end
            end
            PH_DECAY: begin
                if (t_sub <= sus) begin
                    n_level = sus;
                    n_phase = PH_SUSTAIN;
                end else begin
                    n_level = t_sub;
                end
            end
            PH_SUSTAIN: begin
                n_level = sus;
                if (sus == 32'd0) n_phase = PH_OFF;
            end
            PH_RELEASE: begin
                if (r_inc > r_level) begin
                    n_level = 32'd0;
                    n_phase = PH_OFF;
                end else begin
                    n_level = r_level - r_inc;
                end
            end
            default: begin
                n_level = 32'd0;
                n_phase = PH_OFF;
            end
        endcase
    end

    // envelope products, slope operands, interpolation and output
    always_comb begin
        e1_p    = {15'd0, r_level[31:17]} * {15'd0, r_hvel};
        e2_p    = $signed({1'b0, r_e1}) * 32'(r_gain);
        diff    = 17'(r_cur) - 17'(r_prev);
        mag     = diff[16] ? 17'(-diff) : diff;
        sl_p    = (33+IW)'(r_slope) * $signed({33'd0, r_idx});
        if (r_idx < len)
            inter_n = PW'(r_prev) + PW'(sl_p >>> 15);
        else
            inter_n = PW'(r_cur);
        y_p  = (PW+16)'(r_x) * (PW+16)'(r_inter);
        y_sh = y_p[PW+15:12];
        if (y_sh > (PW+4)'(32767))
            y_sat = 16'sd32767;
        else if (y_sh < -(PW+4)'(32768))
            y_sat = -16'sd32768;
        else
            y_sat = y_sh[15:0];
    end

    // divider operand select
    always_comb begin
        div_start = (i_cmd.rise_start && ph_rise && (ms_sel != 15'd0)) || i_cmd.slope_start;
        if (i_cmd.slope_start) begin
            div_a = {1'b0, mag[15:0], 15'd0};
            div_b = len32;
        end else begin
            div_a = range_sel;
            div_b = 32'(ms_sel) * 32'(PER_MS);
        end
    end

    aev_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // hold configuration and envelope state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack    <= RST_ATTACK;
            r_decay     <= RST_DECAY;
            r_sustain   <= RST_SUSTAIN;
            r_release   <= RST_RELEASE;
            r_gain      <= RST_GAIN;
            r_blklen    <= RST_BLKLEN;
            r_phase     <= PH_OFF;
            r_level     <= '0;
            r_hvel      <= '0;
            r_rsl       <= '0;
            r_prev      <= '0;
            r_cur       <= '0;
            r_slope     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_ATTACK:  r_attack  <= i_cfg.data[14:0];
                    REG_DECAY:   r_decay   <= i_cfg.data[14:0];
                    REG_SUSTAIN: r_sustain <= i_cfg.data[14:0];
                    REG_RELEASE: r_release <= i_cfg.data[14:0];
                    REG_GAIN:    r_gain    <= i_cfg.data;
                    REG_BLKLEN:  r_blklen  <= i_cfg.data[8:0];
                    default: ;
                endcase
            end
            if (i_cmd.apply_cmd) begin
                if (r_cmdc == CMD_START) begin
                    r_phase <= PH_ATTACK;
                    r_hvel  <= r_vel;
                end else if (r_cmdc == CMD_STOP && r_phase != PH_OFF) begin
                    r_phase <= PH_RELEASE;
                    r_rsl   <= r_level;
                end
            end
            if (i_cmd.step) begin
                r_phase <= n_phase;
                r_level <= n_level;
            end
            if (i_cmd.env2) begin
                r_idx <= '0;
                if (o_sts.silent) begin
                    r_prev  <= '0;
                    r_cur   <= '0;
                    r_slope <= '0;
                end else begin
                    r_prev <= r_cur;
                    r_cur  <= e2_p[30:15];
                end
            end
            if (i_cmd.slope_fix)
                r_slope <= r_neg ? -$signed(div_q) : $signed(div_q);
            if (i_cmd.interp && r_idx < len)
                r_idx <= r_idx + 1'b1;
            if (i_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;
        end
    end

    // capture request and intermediates
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmdc <= i_in.cmd;
            r_vel  <= i_in.velocity;
            r_bs   <= i_in.block_start;
            r_x    <= i_in.audio_in;
        end
        if (i_cmd.rise_start && ms_sel == 15'd0)
            r_inc <= LEVEL_MAX;
        if (i_cmd.rise_mul)
            r_inc <= (|rise_p[32+IW-1:32]) ? LEVEL_MAX : rise_p[31:0];
        if (i_cmd.env1)
            r_e1 <= e1_p[29:15];
        if (i_cmd.slope_start)
            r_neg <= diff[16];
        if (i_cmd.interp)
            r_inter <= inter_n;
        if (i_cmd.out_load) begin
            r_y     <= y_sat;
            r_env_o <= r_cur;
        end
    end

    // status and ports
    always_comb begin
        o_sts.in_valid    = i_in.valid;
        o_sts.block_start = i_in.block_start;
        o_sts.rise_div    = ph_rise && (ms_sel != 15'd0);
        o_sts.div_done    = div_done;
        o_sts.silent      = (r_phase == PH_OFF) || (r_gain == 16'sd0);
        o_sts.out_free    = !r_out_valid || o_out.ready;
    end

    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.audio_out = r_y;
    assign o_out.env_out   = r_env_o;

`ifndef SYNTHESIS
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_OFF |-> r_level == 32'd0) else $error("off with nonzero level");
    a_silent_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.env2 && o_sts.silent |=> r_cur == 16'sd0 && r_prev == 16'sd0)
        else $error("silent block kept an envelope");
    a_step_only_bs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply_cmd |-> r_bs) else $error("block step without block start");
`endif

endmodule

`default_nettype wire

>>> design/adsr_envelope_vca_unit.sv
// ----------------------------------------------------------------------------
// adsr_envelope_vca_unit: ADSR envelope generator with amplifier
// Shapes a 16-bit audio stream by a per-block ADSR envelope.
// ----------------------------------------------------------------------------
// One sample request is taken at a time. A sample without block start is
// interpolated, then multiplied and loaded into the output register, after
// which the unit returns to idle and can accept the next sample. A sample
// that starts a block first runs the envelope step, which may wait on the
// shared radix-2 divider twice (one pass for the phase increment, one for
// the interpolation slope). A silent block skips the slope pass and a phase
// without a timed ramp skips the increment pass. A result that is not taken
// holds the unit in its output state until the register frees. The result
// register lets the next request enter while a result still waits to be
// taken. Configuration writes are taken at any time (ready held high) and
// must only be issued while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none

module adsr_envelope_vca_unit #(
    parameter int unsigned MAX_BLOCK   = 256,
    parameter int unsigned SAMPLE_RATE = 48000
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    aev_cfg_if.sink   i_cfg,
    aev_in_if.sink    i_in,
    aev_out_if.source o_out
);
    import aev_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    aev_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_ready (in_ready)
    );

    aev_dp #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .i_cfg   (i_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire
